### src/apfp_pkg.sv
// Shared types, character codes and constants for the ASCII position frame parser.
`default_nettype none

package apfp_pkg;

	localparam int ACC_W  = 24;	// decimal magnitude, saturates at MAG_CAP
	localparam int FRAC_W = 3;	// fraction digit count, up to six
	localparam int DEC_W  = 24;
	localparam int SEQ_W  = 32;
	localparam int DT_W   = 16;
	localparam int CNT_W  = 32;
	localparam int TDATA_W = 224;	// 217 payload bits padded to whole bytes

	localparam logic [ACC_W-1:0] MAG_CAP  = 24'h800000;
	localparam logic [DEC_W-1:0] MILLI_HI = 24'h7FFFFF;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_B      = 8'h42;
	localparam logic [7:0] CH_L      = 8'h4C;

	// Position within the line format.
	typedef enum logic [3:0] {
		FP_H_DOLLAR,
		FP_H_B,
		FP_H_A,
		FP_H_L1,
		FP_H_L2,
		FP_H_COMMA,
		FP_SEQ,
		FP_FLAG_FIRST,
		FP_FLAG_REST,
		FP_POS,
		FP_TARGET,
		FP_CONF,
		FP_DT,
		FP_DONE
	} fp_t;

	typedef struct packed {
		logic neg;
		logic sign;
		logic point;
		logic digit;
		logic used;
	} num_flags_t;

	typedef struct packed {
		logic [ACC_W-1:0]  acc;
		num_flags_t        flags;
		logic [FRAC_W-1:0] frac;
	} num_state_t;

	typedef struct packed {
		logic finish;	// terminating comma taken
		logic fail;		// character not allowed here
	} num_ctl_t;

	typedef struct packed {
		logic [CNT_W-1:0] lost_total;
		logic [CNT_W-1:0] seen_total;
		logic [CNT_W-1:0] frames_total;
		logic [DT_W-1:0]  interval_ms;
		logic [DEC_W-1:0] confidence_milli;
		logic [DEC_W-1:0] target_milli;
		logic [DEC_W-1:0] position_milli;
		logic             ball_seen;
		logic [SEQ_W-1:0] frame_number;
	} res_t;

	function automatic logic is_digit(input logic [7:0] b);
		return b inside {[CH_ZERO:CH_NINE]};
	endfunction

	function automatic logic [7:0] head_char(input fp_t fp);
		logic [7:0] c;
		case (fp)
			FP_H_DOLLAR: c = CH_DOLLAR;
			FP_H_B:      c = CH_B;
			FP_H_A:      c = CH_A;
			FP_H_L1:     c = CH_L;
			FP_H_L2:     c = CH_L;
			FP_H_COMMA:  c = CH_COMMA;
			default:     c = CH_COMMA;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### src/apfp_num_unit.sv
// Per-character decimal field step and fixed-point scaling of a finished field.
`default_nettype none

module apfp_num_unit #(
	parameter int FRACTION_DIGITS = 3
) (
	input  wire logic [7:0]               rx_byte,
	input  wire apfp_pkg::num_state_t     cur,
	output apfp_pkg::num_state_t          nxt,
	output apfp_pkg::num_ctl_t            ctl,
	output logic [apfp_pkg::DEC_W-1:0]    value
);

	localparam logic [apfp_pkg::FRAC_W-1:0] FRAC_MAX = apfp_pkg::FRAC_W'(FRACTION_DIGITS);

	always_comb begin : step
		logic leading;
		logic after_sign;
		logic blank;
		logic [27:0] prod;
		nxt        = cur;
		ctl        = '0;
		leading    = !(cur.flags.sign || cur.flags.point || cur.flags.digit);
		after_sign = cur.flags.sign && !(cur.flags.point || cur.flags.digit);
		blank      = rx_byte inside {apfp_pkg::CH_SPACE, apfp_pkg::CH_TAB,
			apfp_pkg::CH_VT, apfp_pkg::CH_FF};
		prod       = {4'b0, cur.acc} * 28'd10 + {24'b0, rx_byte[3:0]};
		if (apfp_pkg::is_digit(rx_byte)) begin
			nxt.flags.digit = 1'b1;
			nxt.flags.used  = 1'b1;
			// fraction digits past the kept places are dropped
			if (!cur.flags.point || cur.frac < FRAC_MAX) begin
				nxt.acc = (prod > {4'b0, apfp_pkg::MAG_CAP}) ? apfp_pkg::MAG_CAP : prod[23:0];
				if (cur.flags.point) nxt.frac = cur.frac + 1'b1;
			end
		end else if (rx_byte == apfp_pkg::CH_DOT && !cur.flags.point) begin
			nxt.flags.point = 1'b1;
			nxt.flags.used  = 1'b1;
		end else if (leading && blank) begin
			nxt.flags.used = 1'b1;
		end else if (leading && (rx_byte == apfp_pkg::CH_PLUS || rx_byte == apfp_pkg::CH_MINUS)) begin
			nxt.flags.sign = 1'b1;
			nxt.flags.used = 1'b1;
			nxt.flags.neg  = (rx_byte == apfp_pkg::CH_MINUS);
		end else if (rx_byte == apfp_pkg::CH_COMMA && (cur.flags.digit || !cur.flags.used)
				&& !after_sign) begin
			ctl.finish = 1'b1;
			nxt        = '0;
		end else begin
			ctl.fail = 1'b1;
		end
	end

	// Scale by ten to the number of fraction places not given. Saturating
	// once on the full product equals saturating after every factor of ten.
	always_comb begin : scale
		logic [apfp_pkg::FRAC_W-1:0] missing;
		logic [19:0] pow;
		logic [43:0] p;
		logic [apfp_pkg::ACC_W-1:0] mag;
		missing = FRAC_MAX - cur.frac;
		case (missing)
			3'd0:    pow = 20'd1;
			3'd1:    pow = 20'd10;
			3'd2:    pow = 20'd100;
			3'd3:    pow = 20'd1000;
			3'd4:    pow = 20'd10000;
			3'd5:    pow = 20'd100000;
			3'd6:    pow = 20'd1000000;
			default: pow = 20'd1;
		endcase
		p   = 44'(cur.acc) * 44'(pow);
		mag = (p > {20'b0, apfp_pkg::MAG_CAP}) ? apfp_pkg::MAG_CAP : p[23:0];
		if (cur.flags.neg) begin
			value = ~mag + 1'b1;
		end else begin
			value = (mag > apfp_pkg::MILLI_HI) ? apfp_pkg::MILLI_HI : mag;
		end
	end

endmodule

`default_nettype wire

### src/apfp_line_parser.sv
// Line state, held fields and frame counters; one received byte per fire.
`default_nettype none

module apfp_line_parser #(
	parameter int LINE_CAPACITY   = 128,
	parameter int FRACTION_DIGITS = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  wire logic [7:0]  rx_byte,
	output logic             res_valid,
	output apfp_pkg::res_t   res
);

	localparam int LEN_W = $clog2(LINE_CAPACITY);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAPACITY - 1);

	logic [LEN_W-1:0]            len_q, len_d;
	apfp_pkg::fp_t               fp_q, fp_d;
	logic                        failed_q, failed_d;
	apfp_pkg::num_state_t        num_q, num_d, num_nxt;
	apfp_pkg::num_ctl_t          num_ctl;
	logic [apfp_pkg::DEC_W-1:0]  num_value;
	logic [apfp_pkg::SEQ_W-1:0]  seq_q, seq_d;
	logic                        flag_q, flag_d;
	logic [apfp_pkg::DEC_W-1:0]  pos_q, pos_d, tgt_q, tgt_d, conf_q, conf_d;
	logic [apfp_pkg::DT_W-1:0]   dt_q, dt_d;
	logic [apfp_pkg::CNT_W-1:0]  frames_q, seen_q, lost_q;
	logic                        eol;
	logic                        digit;

	apfp_num_unit #(
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_num (
		.rx_byte(rx_byte),
		.cur    (num_q),
		.nxt    (num_nxt),
		.ctl    (num_ctl),
		.value  (num_value)
	);

	assign eol   = (rx_byte == apfp_pkg::CH_LF) || (rx_byte == apfp_pkg::CH_CR);
	assign digit = apfp_pkg::is_digit(rx_byte);

	// next state
	always_comb begin
		len_d    = len_q;
		fp_d     = fp_q;
		failed_d = failed_q;
		num_d    = num_q;
		seq_d    = seq_q;
		flag_d   = flag_q;
		pos_d    = pos_q;
		tgt_d    = tgt_q;
		conf_d   = conf_q;
		dt_d     = dt_q;
		if (eol) begin
			if (len_q != '0) begin
				len_d    = '0;
				fp_d     = apfp_pkg::FP_H_DOLLAR;
				failed_d = 1'b0;
				num_d    = '0;
			end
		end else if (len_q < LEN_MAX) begin
			len_d = len_q + 1'b1;
			if (!failed_q) begin
				case (fp_q)
					apfp_pkg::FP_H_DOLLAR, apfp_pkg::FP_H_B, apfp_pkg::FP_H_A,
					apfp_pkg::FP_H_L1, apfp_pkg::FP_H_L2, apfp_pkg::FP_H_COMMA: begin
						if (rx_byte == apfp_pkg::head_char(fp_q)) begin
							fp_d = apfp_pkg::fp_t'(4'(fp_q) + 4'd1);
						end else begin
							failed_d = 1'b1;
						end
						if (fp_q == apfp_pkg::FP_H_DOLLAR) begin
							seq_d = '0;
							dt_d  = '0;
						end
					end
					apfp_pkg::FP_SEQ: begin
						if (digit) seq_d = (seq_q << 3) + (seq_q << 1) + {28'b0, rx_byte[3:0]};
						else if (rx_byte == apfp_pkg::CH_COMMA) fp_d = apfp_pkg::FP_FLAG_FIRST;
						else failed_d = 1'b1;
					end
					apfp_pkg::FP_FLAG_FIRST, apfp_pkg::FP_FLAG_REST: begin
						if (fp_q == apfp_pkg::FP_FLAG_FIRST) flag_d = (rx_byte == apfp_pkg::CH_ONE);
						if (digit) fp_d = apfp_pkg::FP_FLAG_REST;
						else if (rx_byte == apfp_pkg::CH_COMMA) fp_d = apfp_pkg::FP_POS;
						else failed_d = 1'b1;
					end
					apfp_pkg::FP_POS, apfp_pkg::FP_TARGET, apfp_pkg::FP_CONF: begin
						num_d = num_nxt;
						if (num_ctl.fail) failed_d = 1'b1;
						if (num_ctl.finish) begin
							case (fp_q)
								apfp_pkg::FP_POS: begin
									pos_d = num_value;
									fp_d  = apfp_pkg::FP_TARGET;
								end
								apfp_pkg::FP_TARGET: begin
									tgt_d = num_value;
									fp_d  = apfp_pkg::FP_CONF;
								end
								default: begin
									conf_d = num_value;
									fp_d   = apfp_pkg::FP_DT;
								end
							endcase
						end
					end
					apfp_pkg::FP_DT: begin
						if (digit) dt_d = (dt_q << 3) + (dt_q << 1) + {12'b0, rx_byte[3:0]};
						else if (rx_byte == apfp_pkg::CH_HASH) fp_d = apfp_pkg::FP_DONE;
						else failed_d = 1'b1;
					end
					apfp_pkg::FP_DONE: ;	// trailing bytes ignored
					default: failed_d = 1'b1;
				endcase
			end
		end else begin
			// overlong line: drop byte and start over
			len_d    = '0;
			fp_d     = apfp_pkg::FP_H_DOLLAR;
			failed_d = 1'b0;
			num_d    = '0;
		end
	end

	// result
	always_comb begin
		res_valid = fire && eol && (len_q != '0) && !failed_q && (fp_q == apfp_pkg::FP_DONE);
		res.frame_number     = seq_q;
		res.ball_seen        = flag_q;
		res.position_milli   = pos_q;
		res.target_milli     = tgt_q;
		res.confidence_milli = conf_q;
		res.interval_ms      = dt_q;
		res.frames_total     = frames_q + 1'b1;
		res.seen_total       = flag_q ? seen_q + 1'b1 : seen_q;
		res.lost_total       = flag_q ? lost_q : lost_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			fp_q     <= apfp_pkg::FP_H_DOLLAR;
			failed_q <= 1'b0;
			num_q    <= '0;
			seq_q    <= '0;
			flag_q   <= 1'b0;
			pos_q    <= '0;
			tgt_q    <= '0;
			conf_q   <= '0;
			dt_q     <= '0;
			frames_q <= '0;
			seen_q   <= '0;
			lost_q   <= '0;
		end else if (fire) begin
			len_q    <= len_d;
			fp_q     <= fp_d;
			failed_q <= failed_d;
			num_q    <= num_d;
			seq_q    <= seq_d;
			flag_q   <= flag_d;
			pos_q    <= pos_d;
			tgt_q    <= tgt_d;
			conf_q   <= conf_d;
			dt_q     <= dt_d;
			if (res_valid) begin
				frames_q <= res.frames_total;
				seen_q   <= res.seen_total;
				lost_q   <= res.lost_total;
			end
		end
	end

endmodule

`default_nettype wire

### src/ascii_position_frame_parser.sv
// Top level: input byte register, line parser and frame result register.
//
// Usage:
//  - Slave channel (s_tvalid/s_tready/s_tdata) takes one received byte per
//    transaction. Lines look like "$BALL,seq,flag,pos,target,conf,dt#" and are
//    closed by CR or LF; empty lines and failing lines produce nothing.
//  - Master channel (m_tvalid/m_tready/m_tdata) carries one transaction per
//    line that passes: the frame fields plus running frame/seen/lost counts.
//  - Throughput: one byte per cycle, sustained while no frame waits on m_tready. The
//    parser state update for a byte, including the saturating decimal scale, is combinational.
//  - Order: a byte sits in the input register until it is parsed; the frame for a
//    CR/LF enters the result register at the same edge that parses it and drives m_tvalid.
//  - Stall: while a frame waits on m_tready the input register holds; once it
//    is full s_tready drops until the result register frees up.
//  - Reset (arst_n low, asynchronous) clears the line state, held fields and
//    all counters; parsing restarts at the '$' of the header.
//  - A line that grows past LINE_CAPACITY-1 bytes is cut: the byte over the
//    limit is dropped and parsing starts over with the next byte.
`default_nettype none

module ascii_position_frame_parser #(
	parameter int LINE_CAPACITY   = 128,
	parameter int FRACTION_DIGITS = 3
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [7:0]                   s_tdata,	// [7:0] rx_byte
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// [31:0] frame_number, [32] ball_seen, [56:33] position_milli,
	// [80:57] target_milli, [104:81] confidence_milli, [120:105] interval_ms,
	// [152:121] frames_total, [184:153] seen_total, [216:185] lost_total,
	// [223:217] zero
	output logic [apfp_pkg::TDATA_W-1:0]      m_tdata
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           out_free;
	logic           fire;
	logic           res_valid;
	apfp_pkg::res_t res;
	logic           out_valid_q;
	apfp_pkg::res_t out_q;

	assign out_free = !out_valid_q || m_tready;
	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) byte_s1 <= s_tdata;
	end

	apfp_line_parser #(
		.LINE_CAPACITY  (LINE_CAPACITY),
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.rx_byte  (byte_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_q};

	// frame count always splits into seen plus lost
	a_count_split: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_q.frames_total == out_q.seen_total + out_q.lost_total))
		else $error("frame count does not equal seen plus lost");

	// input only backs up behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without a stalled result");

	// a new result always comes from a byte in the input register
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1))
		else $error("result appeared without a parsed byte");

endmodule

`default_nettype wire

### tb/tb_ascii_position_frame_parser.sv
// Self-checking testbench for the ASCII position frame parser: byte stream in, frame records out.
`timescale 1ns / 100ps

module tb_ascii_position_frame_parser;

	localparam int LINE_CAP     = 128;	// matches the DUT default
	localparam int FRAC_DIGITS  = 3;
	localparam int PHASE_BYTES  = 450;	// random bytes per phase
	localparam int HOLD_CYCLES  = 400;	// long receiver hold-off in the last phase
	localparam int QUIET_LIMIT  = 5000;	// cycles with no transaction on either side
	localparam int DRAIN_CYCLES = 20;

	// ------------------------------------------------------------------
	// Frame scoreboard: tracks the parser state byte by byte and keeps
	// the frames that completed lines must produce, oldest first.
	// ------------------------------------------------------------------
	class frame_scoreboard;
		localparam logic [47:0] HEADER = {apfp_pkg::CH_COMMA, apfp_pkg::CH_L, apfp_pkg::CH_L,
			apfp_pkg::CH_A, apfp_pkg::CH_B, apfp_pkg::CH_DOLLAR};
		localparam logic [31:0] MAG_LIMIT = 32'd8388608;
		localparam logic [31:0] POS_LIMIT = 32'd8388607;

		int unsigned          line_len;
		apfp_pkg::fp_t        line_pos;
		logic                 line_bad;
		logic [31:0]          acc;
		apfp_pkg::num_flags_t nf;
		int unsigned          frac_cnt;
		logic [31:0]          seq_val;
		logic                 flag_val;
		logic [23:0]          dec_val [3];
		logic [31:0]          dt_val;
		logic [31:0]          n_frames;
		logic [31:0]          n_seen;
		logic [31:0]          n_lost;
		apfp_pkg::res_t       pending_frames [$];
		int unsigned          mismatches;
		int unsigned          frames_checked;

		function new();
			restart_line();
			seq_val = '0;
			flag_val = 1'b0;
			dec_val[0] = '0;
			dec_val[1] = '0;
			dec_val[2] = '0;
			dt_val = '0;
			n_frames = '0;
			n_seen = '0;
			n_lost = '0;
			mismatches = 0;
			frames_checked = 0;
		endfunction

		function void clear_number();
			acc = '0;
			nf = '0;
			frac_cnt = 0;
		endfunction

		function void restart_line();
			line_len = 0;
			line_pos = apfp_pkg::FP_H_DOLLAR;
			line_bad = 1'b0;
			clear_number();
		endfunction

		// Scale to thousandths, saturate, apply the sign and clamp to 24 bits.
		function void close_decimal(int slot);
			logic [31:0] mag;
			logic [31:0] v;
			int unsigned k;
			mag = acc;
			for (k = frac_cnt; k < FRAC_DIGITS; k++) begin
				mag = mag * 10;
				if (mag > MAG_LIMIT)
					mag = MAG_LIMIT;
			end
			if (nf.neg)
				v = 32'd0 - mag;
			else
				v = (mag > POS_LIMIT) ? POS_LIMIT : mag;
			if (slot >= 0 && slot < 3)
				dec_val[slot] = v[23:0];
			clear_number();
		endfunction

		function void decimal_char(logic [7:0] b, logic is_dig);
			apfp_pkg::num_flags_t f;
			logic leading;
			logic after_sign;
			f = nf;
			leading = !(f.sign || f.point || f.digit);
			after_sign = f.sign && !(f.point || f.digit);
			if (is_dig) begin
				nf.digit = 1'b1;
				nf.used = 1'b1;
				// fraction digits past the scale are dropped (truncation)
				if (!f.point || frac_cnt < FRAC_DIGITS) begin
					acc = acc * 10 + 32'(b - apfp_pkg::CH_ZERO);
					if (acc > MAG_LIMIT)
						acc = MAG_LIMIT;
					if (f.point)
						frac_cnt++;
				end
			end else if (b == apfp_pkg::CH_DOT && !f.point) begin
				nf.point = 1'b1;
				nf.used = 1'b1;
			end else if (leading && b inside {apfp_pkg::CH_SPACE, apfp_pkg::CH_TAB,
					apfp_pkg::CH_VT, apfp_pkg::CH_FF}) begin
				nf.used = 1'b1;
			end else if (leading && (b == apfp_pkg::CH_PLUS || b == apfp_pkg::CH_MINUS)) begin
				nf.sign = 1'b1;
				nf.used = 1'b1;
				if (b == apfp_pkg::CH_MINUS)
					nf.neg = 1'b1;
			end else if (b == apfp_pkg::CH_COMMA && (f.digit || !f.used) && !after_sign) begin
				close_decimal(int'(line_pos) - int'(apfp_pkg::FP_POS));
				line_pos = apfp_pkg::fp_t'(line_pos + 1);
			end else begin
				line_bad = 1'b1;
			end
		endfunction

		function void parse_char(logic [7:0] b);
			logic is_dig;
			apfp_pkg::fp_t fp;
			is_dig = (b >= apfp_pkg::CH_ZERO && b <= apfp_pkg::CH_NINE);
			fp = line_pos;
			if (fp < apfp_pkg::FP_SEQ) begin
				if (b == HEADER[8 * int'(fp) +: 8])
					line_pos = apfp_pkg::fp_t'(fp + 1);
				else
					line_bad = 1'b1;
			end else if (fp == apfp_pkg::FP_SEQ) begin
				if (is_dig)
					seq_val = seq_val * 10 + 32'(b - apfp_pkg::CH_ZERO);
				else if (b == apfp_pkg::CH_COMMA)
					line_pos = apfp_pkg::FP_FLAG_FIRST;
				else
					line_bad = 1'b1;
			end else if (fp == apfp_pkg::FP_FLAG_FIRST || fp == apfp_pkg::FP_FLAG_REST) begin
				if (fp == apfp_pkg::FP_FLAG_FIRST)
					flag_val = (b == apfp_pkg::CH_ONE);
				if (is_dig)
					line_pos = apfp_pkg::FP_FLAG_REST;
				else if (b == apfp_pkg::CH_COMMA)
					line_pos = apfp_pkg::FP_POS;
				else
					line_bad = 1'b1;
			end else if (fp >= apfp_pkg::FP_POS && fp <= apfp_pkg::FP_CONF) begin
				decimal_char(b, is_dig);
			end else if (fp == apfp_pkg::FP_DT) begin
				if (is_dig)
					dt_val = dt_val * 10 + 32'(b - apfp_pkg::CH_ZERO);
				else if (b == apfp_pkg::CH_HASH)
					line_pos = apfp_pkg::FP_DONE;
				else
					line_bad = 1'b1;
			end
			// anything after the '#' is ignored
			if (fp == apfp_pkg::FP_H_DOLLAR) begin
				seq_val = '0;
				dt_val = '0;
			end
		endfunction

		// Called for every accepted input transaction.
		function void note_byte(logic [7:0] b);
			apfp_pkg::res_t r;
			logic ok;
			if (b == apfp_pkg::CH_LF || b == apfp_pkg::CH_CR) begin
				if (line_len == 0)
					return;
				ok = !line_bad && line_pos == apfp_pkg::FP_DONE;
				restart_line();
				if (!ok)
					return;
				n_frames++;
				if (flag_val)
					n_seen++;
				else
					n_lost++;
				r.frame_number     = seq_val;
				r.ball_seen        = flag_val;
				r.position_milli   = dec_val[0];
				r.target_milli     = dec_val[1];
				r.confidence_milli = dec_val[2];
				r.interval_ms      = dt_val[15:0];
				r.frames_total     = n_frames;
				r.seen_total       = n_seen;
				r.lost_total       = n_lost;
				pending_frames.push_back(r);
			end else if (line_len < LINE_CAP - 1) begin
				line_len++;
				if (!line_bad)
					parse_char(b);
			end else begin
				// overlong: this byte is dropped and the line starts over
				restart_line();
			end
		endfunction

		task report(string what, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (mismatches <= 20)
				$display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
		endtask

		// Called for every accepted output transaction.
		task check_frame(logic [apfp_pkg::TDATA_W-1:0] beat);
			apfp_pkg::res_t got;
			apfp_pkg::res_t want;
			got = beat[$bits(apfp_pkg::res_t)-1:0];
			if (pending_frames.size() == 0) begin
				report("frame with none pending", '0, got.frame_number);
				return;
			end
			want = pending_frames.pop_front();
			frames_checked++;
			if (got.frame_number != want.frame_number)
				report("frame_number", want.frame_number, got.frame_number);
			if (got.ball_seen != want.ball_seen)
				report("ball_seen", 32'(want.ball_seen), 32'(got.ball_seen));
			if (got.position_milli != want.position_milli)
				report("position_milli", 32'(want.position_milli), 32'(got.position_milli));
			if (got.target_milli != want.target_milli)
				report("target_milli", 32'(want.target_milli), 32'(got.target_milli));
			if (got.confidence_milli != want.confidence_milli)
				report("confidence_milli", 32'(want.confidence_milli),
					32'(got.confidence_milli));
			if (got.interval_ms != want.interval_ms)
				report("interval_ms", 32'(want.interval_ms), 32'(got.interval_ms));
			if (got.frames_total != want.frames_total)
				report("frames_total", want.frames_total, got.frames_total);
			if (got.seen_total != want.seen_total)
				report("seen_total", want.seen_total, got.seen_total);
			if (got.lost_total != want.lost_total)
				report("lost_total", want.lost_total, got.lost_total);
			if (beat[apfp_pkg::TDATA_W-1:$bits(apfp_pkg::res_t)] != '0)
				report("tdata padding", '0,
					32'(beat[apfp_pkg::TDATA_W-1:$bits(apfp_pkg::res_t)]));
		endtask
	endclass

	// ------------------------------------------------------------------
	// DUT and its stream channels
	// ------------------------------------------------------------------
	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [7:0]                   s_tdata = 8'h00;	// [7:0] rx_byte
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	// [31:0] frame_number, [32] ball_seen, [56:33] position_milli,
	// [80:57] target_milli, [104:81] confidence_milli, [120:105] interval_ms,
	// [152:121] frames_total, [184:153] seen_total, [216:185] lost_total,
	// [223:217] zero
	logic [apfp_pkg::TDATA_W-1:0] m_tdata;

	ascii_position_frame_parser i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	frame_scoreboard scoreboard = new();

	int          src_idle_pct = 26;	// percent of cycles the sender idles
	int          snk_idle_pct = 86;	// percent of cycles the receiver stalls
	bit          hold_req = 1'b0;	// asks the receiver for one long hold-off
	int unsigned bytes_sent = 0;
	int unsigned quiet_cycles = 0;
	int unsigned lines_good = 0;
	int unsigned lines_broken = 0;
	int unsigned lines_noise = 0;
	int unsigned lines_long = 0;
	logic [7:0]  tx_bytes [$];	// bytes of the line being assembled

	// ------------------------------------------------------------------
	// Receiver: random backpressure, plus one long hold-off on request so
	// the result register stays full and the DUT stalls its input.
	// ------------------------------------------------------------------
	initial begin
		int hold_count;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				hold_count = 0;
				while (hold_count < HOLD_CYCLES) begin
					@(posedge clk);
					hold_count++;
				end
			end else begin
				m_tready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// Monitor and watchdog. Sampling at the falling edge: inputs only move
	// at the rising edge, so what is seen here is what the next rising edge
	// takes.
	always @(negedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				scoreboard.check_frame(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
					$display("CHECK FAILED");
					$finish;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// One input transaction; entered and left right after a rising edge.
	task automatic send_byte(logic [7:0] b);
		if ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < src_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		scoreboard.note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_buf();
		foreach (tx_bytes[i])
			send_byte(tx_bytes[i]);
		tx_bytes.delete();
	endtask

	function automatic void put_str(string s);
		for (int i = 0; i < s.len(); i++)
			tx_bytes.push_back(s[i]);
	endfunction

	function automatic void put_digits(int n);
		repeat (n)
			tx_bytes.push_back(8'(apfp_pkg::CH_ZERO + $urandom_range(9)));
	endfunction

	// Decimal field: optional blanks, optional sign, digits with at most one
	// point. Sometimes empty, sometimes long enough to saturate.
	function automatic void put_decimal();
		int int_digits;
		int frac_digits;
		bit has_point;
		int sign_pick;
		if ($urandom_range(19) == 0)
			return;
		if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(1, 2)) begin
				case ($urandom_range(3))
					0: tx_bytes.push_back(apfp_pkg::CH_SPACE);
					1: tx_bytes.push_back(apfp_pkg::CH_TAB);
					2: tx_bytes.push_back(apfp_pkg::CH_VT);
					default: tx_bytes.push_back(apfp_pkg::CH_FF);
				endcase
			end
		end
		sign_pick = $urandom_range(3);
		if (sign_pick == 0)
			tx_bytes.push_back(apfp_pkg::CH_PLUS);
		else if (sign_pick == 1)
			tx_bytes.push_back(apfp_pkg::CH_MINUS);
		int_digits = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 4);
		has_point = $urandom_range(1);
		frac_digits = $urandom_range(0, 5);
		if (int_digits == 0 && (!has_point || frac_digits == 0))
			int_digits = 1;
		put_digits(int_digits);
		if (has_point) begin
			tx_bytes.push_back(apfp_pkg::CH_DOT);
			put_digits(frac_digits);
		end
	endfunction

	// Well-formed "$BALL,seq,flag,pos,target,conf,dt#" without terminator.
	function automatic void put_good_line();
		int flag_len;
		tx_bytes.push_back(apfp_pkg::CH_DOLLAR);
		tx_bytes.push_back(apfp_pkg::CH_B);
		tx_bytes.push_back(apfp_pkg::CH_A);
		tx_bytes.push_back(apfp_pkg::CH_L);
		tx_bytes.push_back(apfp_pkg::CH_L);
		tx_bytes.push_back(apfp_pkg::CH_COMMA);
		put_digits(($urandom_range(9) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 5));
		tx_bytes.push_back(apfp_pkg::CH_COMMA);
		flag_len = $urandom_range(0, 3);
		if (flag_len > 0) begin
			tx_bytes.push_back($urandom_range(1) ? apfp_pkg::CH_ONE :
				8'(apfp_pkg::CH_ZERO + $urandom_range(9)));
			put_digits(flag_len - 1);
		end
		tx_bytes.push_back(apfp_pkg::CH_COMMA);
		repeat (3) begin
			put_decimal();
			tx_bytes.push_back(apfp_pkg::CH_COMMA);
		end
		put_digits(($urandom_range(9) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 4));
		tx_bytes.push_back(apfp_pkg::CH_HASH);
		// ignored tail after the '#'
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 4))
				tx_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
	endfunction

	// CR or LF; CR LF now and then, whose LF is an empty line
	function automatic void put_end();
		if ($urandom_range(1)) begin
			tx_bytes.push_back(apfp_pkg::CH_CR);
			if ($urandom_range(5) == 0)
				tx_bytes.push_back(apfp_pkg::CH_LF);
		end else begin
			tx_bytes.push_back(apfp_pkg::CH_LF);
		end
	endfunction

	// Replace, insert or delete one byte at a random spot.
	function automatic void mangle_line();
		int idx;
		logic [7:0] junk;
		idx = $urandom_range(tx_bytes.size() - 1);
		junk = 8'($urandom);
		case ($urandom_range(2))
			0: tx_bytes[idx] = junk;
			1: tx_bytes.insert(idx, junk);
			default: tx_bytes.delete(idx);
		endcase
	endfunction

	task automatic send_random_line();
		int kind;
		int target_len;
		kind = $urandom_range(99);
		if (kind < 68) begin
			put_good_line();
			lines_good++;
		end else if (kind < 82) begin
			put_good_line();
			repeat ($urandom_range(1, 2))
				mangle_line();
			lines_broken++;
		end else if (kind < 90) begin
			// raw noise, any byte value including terminators
			repeat ($urandom_range(1, 24))
				tx_bytes.push_back(8'($urandom));
			lines_noise++;
		end else if (kind < 94) begin
			// nothing: just the terminator, an empty line
		end else if (kind < 98) begin
			// padded around the length limit: some pass, some are cut
			put_good_line();
			target_len = $urandom_range(LINE_CAP - 4, LINE_CAP + 2);
			while (tx_bytes.size() < target_len)
				tx_bytes.push_back(apfp_pkg::CH_SPACE);
			lines_long++;
		end else begin
			// a full line of junk, one dropped byte, then a good line that
			// must parse from scratch
			repeat (LINE_CAP)
				tx_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
			put_good_line();
			lines_long++;
		end
		put_end();
		send_buf();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int unsigned directed_bytes;
		int phase;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty line, all fields empty, extremes with wrap and
		// saturation, blanks and sign before a point, and a malformed line.
		tx_bytes.push_back(apfp_pkg::CH_CR);
		put_str("$BALL,,,,,,#");
		tx_bytes.push_back(apfp_pkg::CH_LF);
		put_str("$BALL,4294967296,1,-8388.608,99999999.99999,");
		tx_bytes.push_back(apfp_pkg::CH_TAB);
		tx_bytes.push_back(apfp_pkg::CH_VT);
		put_str(" +.5,65536#x,#");
		tx_bytes.push_back(apfp_pkg::CH_CR);
		put_str("$BALL,4294967295,10,8388.607,-99999999,0.0009,65535#");
		tx_bytes.push_back(apfp_pkg::CH_LF);
		put_str("$BALL,7,1,+,1e3,inf,0x1#");
		tx_bytes.push_back(apfp_pkg::CH_LF);
		send_buf();
		directed_bytes = bytes_sent;

		// Random: sender mostly busy / receiver slow, then swapped, then
		// full rate with one long receiver hold-off.
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 26;
					snk_idle_pct = 86;
				end
				1: begin
					src_idle_pct = 86;
					snk_idle_pct = 26;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
					hold_req = 1'b1;
				end
			endcase
			while (bytes_sent < directed_bytes + (phase + 1) * PHASE_BYTES)
				send_random_line();
		end
		s_tvalid <= 1'b0;

		while (scoreboard.pending_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Drove %0d bytes: %0d well-formed, %0d damaged, %0d noise, %0d overlong lines",
			bytes_sent, lines_good, lines_broken, lines_noise, lines_long);
		$display("Compared %0d frames, %0d mismatches",
			scoreboard.frames_checked, scoreboard.mismatches);
		if (scoreboard.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
src/apfp_pkg.sv
src/apfp_num_unit.sv
src/apfp_line_parser.sv
src/ascii_position_frame_parser.sv
tb/tb_ascii_position_frame_parser.sv
